// File: src/chs_pkg.sv
package chs_pkg;

    localparam int BUCKETS_DEF    = 11;
    localparam int POOL_NODES_DEF = 64;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;
    localparam int BUCKET_W = 4;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;
    localparam int S_PAD_W  = S_DATA_W - MODE_W - KEY_W;
    localparam int M_PAD_W  = M_DATA_W - STATUS_W - BUCKET_W;
    localparam int CNT_W    = $clog2(KEY_W + 1);

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [BUCKET_W-1:0] bucket_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_DELETE = 2'd1;

    localparam status_t STAT_INSERTED  = 3'd0;
    localparam status_t STAT_DUPLICATE = 3'd1;
    localparam status_t STAT_DELETED   = 3'd2;
    localparam status_t STAT_DEL_MISS  = 3'd3;
    localparam status_t STAT_FOUND     = 3'd4;
    localparam status_t STAT_SRCH_MISS = 3'd5;
    localparam status_t STAT_FULL      = 3'd6;

    // request walking along the row of node cells
    typedef struct packed {
        mode_t mode;
        key_t  key;
        logic  found;
        logic  claimed;
    } token_t;

    // end-of-walk broadcast to every cell
    typedef struct packed {
        logic commit;
        logic drop;
    } settle_t;

endpackage

// File: src/chs_cell.sv
module chs_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_vld_in,
    input  chs_pkg::token_t   tok_in,
    input  chs_pkg::settle_t  settle,
    output logic              tok_vld_out,
    output chs_pkg::token_t   tok_out
);

    logic              valid_reg;
    logic              valid_next;
    logic              pend_reg;
    logic              pend_next;
    chs_pkg::key_t     key_reg;
    chs_pkg::key_t     key_next;
    logic              tok_vld_reg;
    chs_pkg::token_t   tok_reg;
    chs_pkg::token_t   tok_next;
    logic              is_ins;
    logic              is_del;
    logic              match;
    logic              take;

    always_comb
    begin
        is_ins = (tok_in.mode == chs_pkg::MODE_INSERT);
        is_del = (tok_in.mode == chs_pkg::MODE_DELETE);
        match  = tok_vld_in && valid_reg && (key_reg == tok_in.key);
        take   = tok_vld_in && is_ins && !tok_in.claimed && !valid_reg && !pend_reg;

        valid_next = valid_reg;
        if (settle.commit && pend_reg)
        begin
            valid_next = 1'b1;
        end
        else if (is_del && match)
        begin
            valid_next = 1'b0;
        end

        pend_next = pend_reg;
        if (settle.commit || settle.drop)
        begin
            pend_next = 1'b0;
        end
        else if (take)
        begin
            pend_next = 1'b1;
        end

        key_next = take ? tok_in.key : key_reg;

        tok_next         = tok_in;
        tok_next.found   = tok_in.found | match;
        tok_next.claimed = tok_in.claimed | take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pend_reg    <= pend_next;
            tok_vld_reg <= tok_vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tok_reg <= tok_next;
    end

    assign tok_vld_out = tok_vld_reg;
    assign tok_out     = tok_reg;

endmodule

// File: src/chs_rem.sv
module chs_rem #(
    parameter int BUCKETS = chs_pkg::BUCKETS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  chs_pkg::key_t               key,
    output logic                        done,
    output logic [$clog2(BUCKETS)-1:0]  rem
);

    localparam int RW    = $clog2(BUCKETS);
    localparam int DIG_W = 8;
    localparam int STEPS = (chs_pkg::KEY_W + DIG_W - 1) / DIG_W;
    localparam int SH_W  = STEPS * DIG_W;

    logic              busy_reg;
    logic              busy_next;
    chs_pkg::cnt_t     cnt_reg;
    chs_pkg::cnt_t     cnt_next;
    logic [SH_W-1:0]   sh_reg;
    logic [SH_W-1:0]   sh_next;
    logic [RW-1:0]     r_reg;
    logic [RW-1:0]     r_next;
    logic [RW-1:0]     acc;
    logic [RW:0]       trial;

    always_comb
    begin
        acc       = r_reg;
        trial     = '0;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = chs_pkg::cnt_t'(STEPS);
            sh_next   = SH_W'(key);
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            // eight key bits per step, remainder kept below BUCKETS
            for (int b = 0; b < DIG_W; b++)
            begin
                trial = {acc, sh_reg[SH_W-1-b]};
                if (trial >= (RW+1)'(BUCKETS))
                begin
                    acc = RW'(trial - (RW+1)'(BUCKETS));
                end
                else
                begin
                    acc = RW'(trial);
                end
            end
            r_next   = acc;
            sh_next  = {sh_reg[SH_W-DIG_W-1:0], {DIG_W{1'b0}}};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == chs_pkg::cnt_t'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        r_reg  <= r_next;
    end

    assign done = !busy_reg;
    assign rem  = r_reg;

endmodule

// File: src/chained_hash_set.sv
// Set of unsigned 31-bit keys with insert, delete and search. Each stored key
// sits in one of POOL_NODES node cells laid out as a row; a request enters the
// first cell and moves one cell per clock, so every cell sees it once, and a
// free cell is reserved on the way for an insert and made valid at the end
// unless the key turned out to be present. The bucket index, key modulo
// BUCKETS, comes from a remainder unit that folds in eight key bits per cycle
// and runs alongside the walk. One request is handled at a time: its result
// enters the output register once the walk and the remainder are done and no
// earlier result still waits there, and the next request can be taken in the
// cycle after the result enters the output register. The output register lets
// the next request start while a result waits to be taken.
module chained_hash_set #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [chs_pkg::S_DATA_W-1:0]  s_tdata,  // mode[1:0], key[32:2], zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [chs_pkg::M_DATA_W-1:0]  m_tdata   // status[2:0], bucket[6:3], zero pad
);

    localparam int RW = $clog2(BUCKETS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    chs_pkg::mode_t               mode_reg;
    chs_pkg::mode_t               mode_next;
    logic                         found_reg;
    logic                         found_next;
    logic                         claimed_reg;
    logic                         claimed_next;
    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic [chs_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [chs_pkg::M_DATA_W-1:0] m_tdata_next;

    logic                         accept;
    logic                         fin;
    logic                         rem_done;
    logic [RW-1:0]                rem;
    chs_pkg::status_t             status;
    chs_pkg::settle_t             settle;
    chs_pkg::mode_t               in_mode;
    chs_pkg::key_t                in_key;

    logic                         tok_vld [0:POOL_NODES];
    chs_pkg::token_t              tok     [0:POOL_NODES];

    assign in_mode = s_tdata[chs_pkg::MODE_W-1:0];
    assign in_key  = s_tdata[chs_pkg::MODE_W +: chs_pkg::KEY_W];
    assign accept  = s_tvalid && s_tready;

    assign tok_vld[0]     = accept;
    assign tok[0].mode    = in_mode;
    assign tok[0].key     = in_key;
    assign tok[0].found   = 1'b0;
    assign tok[0].claimed = 1'b0;

    genvar i;
    generate
        for (i = 0; i < POOL_NODES; i++)
        begin : g_cell
            chs_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .tok_vld_in  (tok_vld[i]),
                .tok_in      (tok[i]),
                .settle      (settle),
                .tok_vld_out (tok_vld[i+1]),
                .tok_out     (tok[i+1])
            );
        end
    endgenerate

    chs_rem #(
        .BUCKETS (BUCKETS)
    ) u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (in_key),
        .done  (rem_done),
        .rem   (rem)
    );

    always_comb
    begin
        fin = (state_reg == S_FINISH) && rem_done && (!m_tvalid_reg || m_tready);

        case (mode_reg)
            chs_pkg::MODE_INSERT:
            begin
                if (found_reg)
                begin
                    status = chs_pkg::STAT_DUPLICATE;
                end
                else if (claimed_reg)
                begin
                    status = chs_pkg::STAT_INSERTED;
                end
                else
                begin
                    status = chs_pkg::STAT_FULL;
                end
            end
            chs_pkg::MODE_DELETE:
            begin
                status = found_reg ? chs_pkg::STAT_DELETED : chs_pkg::STAT_DEL_MISS;
            end
            default:
            begin
                status = found_reg ? chs_pkg::STAT_FOUND : chs_pkg::STAT_SRCH_MISS;
            end
        endcase

        settle.commit = fin && (mode_reg == chs_pkg::MODE_INSERT) && !found_reg && claimed_reg;
        settle.drop   = fin;

        state_next    = state_reg;
        mode_next     = mode_reg;
        found_next    = found_reg;
        claimed_next  = claimed_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_mode;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (tok_vld[POOL_NODES])
                begin
                    found_next   = tok[POOL_NODES].found;
                    claimed_next = tok[POOL_NODES].claimed;
                    state_next   = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (fin)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{chs_pkg::M_PAD_W{1'b0}}, chs_pkg::bucket_t'(rem), status};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= chs_pkg::MODE_INSERT;
            found_reg    <= 1'b0;
            claimed_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            found_reg    <= found_next;
            claimed_reg  <= claimed_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: src/chs_check.sv
module chs_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [chs_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [chs_pkg::M_DATA_W-1:0]  m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    // no result right after a transfer in
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // status code and padding legal
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] != 3'd7) && (m_tdata[7] == 1'b0))
        else $error("illegal result word");

    // input payload watched for completeness
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !$isunknown(s_tdata[32:0]))
        else $error("unknown request word");

endmodule

bind chained_hash_set chs_check u_chs_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
